// ===== sv/sqc_pkg.sv =====
package sqc_pkg;

    // Length counter full scale; the counter width follows from it.
    localparam int LENGTH_MAX = 64;
    localparam int LEN_W      = $clog2(LENGTH_MAX + 1);

    localparam int FREQ_W = 11;
    localparam int PT_W   = FREQ_W + 3;

    // Actions
    localparam logic [2:0] ACT_WRITE  = 3'd0;
    localparam logic [2:0] ACT_READ   = 3'd1;
    localparam logic [2:0] ACT_TICK   = 3'd2;
    localparam logic [2:0] ACT_LENGTH = 3'd3;
    localparam logic [2:0] ACT_SWEEP  = 3'd4;
    localparam logic [2:0] ACT_ENV    = 3'd5;

    // Register indexes
    localparam logic [2:0] REG_SWEEP   = 3'd0;
    localparam logic [2:0] REG_DUTY    = 3'd1;
    localparam logic [2:0] REG_ENV     = 3'd2;
    localparam logic [2:0] REG_FREQ_LO = 3'd3;
    localparam logic [2:0] REG_FREQ_HI = 3'd4;

    localparam logic [7:0] DUTY_PATTERN [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] reg_index;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] output_level;
        logic       channel_on;
    } t_result;

    // The sequencer plays the pattern from its top bit down.
    function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
        logic [7:0] pat;
        pat = DUTY_PATTERN[sel];
        return pat[~step];
    endfunction

endpackage

// ===== sv/sqc_in_stage.sv =====
module sqc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sqc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output sqc_pkg::t_item o_item
);

    logic           r_valid;
    sqc_pkg::t_item r_item;
    logic           n_valid;

    assign o_ready = ~r_valid | i_pop;
    assign n_valid = (i_valid & o_ready) | (r_valid & ~i_pop);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_pop |=> r_valid && $stable(r_item))
        else $error("held item lost or changed");

endmodule

// ===== sv/sqc_core.sv =====
module sqc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  sqc_pkg::t_item   i_item,
    output sqc_pkg::t_result o_result
);

    localparam int LEN_W  = sqc_pkg::LEN_W;
    localparam int FREQ_W = sqc_pkg::FREQ_W;
    localparam int PT_W   = sqc_pkg::PT_W;

    logic [2:0]        r_sweep_period_load, n_sweep_period_load;
    logic              r_sweep_subtract, n_sweep_subtract;
    logic [2:0]        r_sweep_shift, n_sweep_shift;
    logic [1:0]        r_duty_select, n_duty_select;
    logic [LEN_W-1:0]  r_length_count, n_length_count;
    logic [3:0]        r_volume_load, n_volume_load;
    logic              r_env_increase, n_env_increase;
    logic [2:0]        r_env_period_load, n_env_period_load;
    logic [FREQ_W-1:0] r_freq_value, n_freq_value;
    logic              r_length_on, n_length_on;
    logic              r_enabled, n_enabled;
    logic              r_sweep_active, n_sweep_active;
    logic [FREQ_W-1:0] r_shadow_freq, n_shadow_freq;
    logic [3:0]        r_sweep_timer, n_sweep_timer;
    logic [3:0]        r_env_timer, n_env_timer;
    logic              r_env_running, n_env_running;
    logic [3:0]        r_cur_volume, n_cur_volume;
    logic [PT_W-1:0]   r_period_timer, n_period_timer;
    logic [2:0]        r_duty_step, n_duty_step;
    logic              r_trigger_seen, n_trigger_seen;

    logic [FREQ_W-1:0] trig_freq;
    logic [FREQ_W:0]   trig_sweep;
    logic [FREQ_W:0]   sweep_first;
    logic [FREQ_W:0]   sweep_second;
    logic [3:0]        sweep_reload;
    logic [7:0]        rd;
    logic [LEN_W-1:0]  len_used;

    // Next sweep frequency; the top bit flags a result above the 11-bit range.
    function automatic logic [FREQ_W:0] sweep_calc(input logic [FREQ_W-1:0] s,
                                                    input logic sub,
                                                    input logic [2:0] sh);
        logic [FREQ_W-1:0] delta;
        delta = s >> sh;
        return sub ? ({1'b0, s} - {1'b0, delta}) : ({1'b0, s} + {1'b0, delta});
    endfunction

    function automatic logic [PT_W-1:0] period_reload(input logic [FREQ_W-1:0] f);
        logic [FREQ_W:0] span;
        span = (FREQ_W + 1)'(1 << FREQ_W) - {1'b0, f};
        return {span, 2'b00};
    endfunction

    assign trig_freq    = {i_item.write_data[2:0], r_freq_value[7:0]};
    assign trig_sweep   = sweep_calc(trig_freq, r_sweep_subtract, r_sweep_shift);
    assign sweep_first  = sweep_calc(r_shadow_freq, r_sweep_subtract, r_sweep_shift);
    assign sweep_second = sweep_calc(sweep_first[FREQ_W-1:0], r_sweep_subtract,
                                     r_sweep_shift);
    // A sweep period of zero counts as eight.
    assign sweep_reload = (r_sweep_period_load != 3'd0) ? {1'b0, r_sweep_period_load}
                                                        : 4'd8;
    assign len_used     = LEN_W'(sqc_pkg::LENGTH_MAX) - r_length_count;

    always_comb begin
        logic [7:0] d;
        logic [3:0] st_dec;
        logic [3:0] et_dec;
        d = i_item.write_data;
        st_dec = '0;
        et_dec = '0;
        rd = 8'd0;

        n_sweep_period_load = r_sweep_period_load;
        n_sweep_subtract    = r_sweep_subtract;
        n_sweep_shift       = r_sweep_shift;
        n_duty_select       = r_duty_select;
        n_length_count      = r_length_count;
        n_volume_load       = r_volume_load;
        n_env_increase      = r_env_increase;
        n_env_period_load   = r_env_period_load;
        n_freq_value        = r_freq_value;
        n_length_on         = r_length_on;
        n_enabled           = r_enabled;
        n_sweep_active      = r_sweep_active;
        n_shadow_freq       = r_shadow_freq;
        n_sweep_timer       = r_sweep_timer;
        n_env_timer         = r_env_timer;
        n_env_running       = r_env_running;
        n_cur_volume        = r_cur_volume;
        n_period_timer      = r_period_timer;
        n_duty_step         = r_duty_step;
        n_trigger_seen      = r_trigger_seen;

        case (i_item.action)
            sqc_pkg::ACT_WRITE: begin
                case (i_item.reg_index)
                    sqc_pkg::REG_SWEEP: begin
                        n_sweep_period_load = d[6:4];
                        n_sweep_subtract    = d[3];
                        n_sweep_shift       = d[2:0];
                    end
                    sqc_pkg::REG_DUTY: begin
                        n_duty_select  = d[7:6];
                        n_length_count = LEN_W'(sqc_pkg::LENGTH_MAX) - LEN_W'(d[5:0]);
                    end
                    sqc_pkg::REG_ENV: begin
                        n_volume_load     = d[7:4];
                        n_env_increase    = d[3];
                        n_env_period_load = d[2:0];
                    end
                    sqc_pkg::REG_FREQ_LO: begin
                        n_freq_value = {r_freq_value[FREQ_W-1:8], d};
                    end
                    sqc_pkg::REG_FREQ_HI: begin
                        n_length_on    = d[6];
                        n_freq_value   = trig_freq;
                        n_trigger_seen = d[7];
                        if (d[7]) begin
                            n_enabled = 1'b1;
                            if (r_length_count == '0) begin
                                n_length_count = LEN_W'(sqc_pkg::LENGTH_MAX);
                            end
                            n_period_timer = period_reload(trig_freq);
                            n_env_timer    = {1'b0, r_env_period_load};
                            n_cur_volume   = r_volume_load;
                            n_env_running  = 1'b1;
                            n_shadow_freq  = trig_freq;
                            n_sweep_timer  = sweep_reload;
                            n_sweep_active = (r_sweep_period_load != 3'd0) ||
                                             (r_sweep_shift != 3'd0);
                            // The overflow check on trigger can silence the channel at once.
                            if (r_sweep_shift != 3'd0 && trig_sweep[FREQ_W]) begin
                                n_enabled = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sqc_pkg::ACT_READ: begin
                case (i_item.reg_index)
                    sqc_pkg::REG_SWEEP:
                        rd = {1'b0, r_sweep_period_load, r_sweep_subtract, r_sweep_shift};
                    sqc_pkg::REG_DUTY:
                        rd = {r_duty_select, len_used[5:0]};
                    sqc_pkg::REG_ENV:
                        rd = {r_volume_load, r_env_increase, r_env_period_load};
                    sqc_pkg::REG_FREQ_LO:
                        rd = r_freq_value[7:0];
                    sqc_pkg::REG_FREQ_HI:
                        rd = {r_trigger_seen, r_length_on, 3'b000, r_freq_value[10:8]};
                    default:
                        rd = 8'd0;
                endcase
            end
            sqc_pkg::ACT_TICK: begin
                if (r_period_timer <= PT_W'(1)) begin
                    n_period_timer = period_reload(r_freq_value);
                    n_duty_step    = r_duty_step + 3'd1;
                end else begin
                    n_period_timer = r_period_timer - PT_W'(1);
                end
            end
            sqc_pkg::ACT_LENGTH: begin
                if (r_length_on && r_length_count != '0) begin
                    n_length_count = r_length_count - LEN_W'(1);
                    if (r_length_count == LEN_W'(1)) begin
                        n_enabled = 1'b0;
                    end
                end
            end
            sqc_pkg::ACT_SWEEP: begin
                st_dec = (r_sweep_timer != 4'd0) ? r_sweep_timer - 4'd1 : 4'd0;
                n_sweep_timer = st_dec;
                if (st_dec == 4'd0) begin
                    n_sweep_timer = sweep_reload;
                    if (r_sweep_active && r_sweep_period_load != 3'd0) begin
                        if (sweep_first[FREQ_W]) begin
                            n_enabled = 1'b0;
                        end else if (r_sweep_shift != 3'd0) begin
                            n_shadow_freq = sweep_first[FREQ_W-1:0];
                            n_freq_value  = sweep_first[FREQ_W-1:0];
                            // A second look ahead from the new frequency.
                            if (sweep_second[FREQ_W]) begin
                                n_enabled = 1'b0;
                            end
                        end
                    end
                end
            end
            sqc_pkg::ACT_ENV: begin
                if (r_env_period_load != 3'd0) begin
                    et_dec = (r_env_timer != 4'd0) ? r_env_timer - 4'd1 : 4'd0;
                    n_env_timer = et_dec;
                    if (et_dec == 4'd0) begin
                        n_env_timer = {1'b0, r_env_period_load};
                        if (r_env_running) begin
                            if (r_env_increase && r_cur_volume != 4'd15) begin
                                n_cur_volume = r_cur_volume + 4'd1;
                            end else if (!r_env_increase && r_cur_volume != 4'd0) begin
                                n_cur_volume = r_cur_volume - 4'd1;
                            end
                            if (n_cur_volume == 4'd0 || n_cur_volume == 4'd15) begin
                                n_env_running = 1'b0;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.read_data    = rd;
        o_result.output_level = (n_enabled && sqc_pkg::duty_bit(n_duty_select, n_duty_step))
                                ? n_cur_volume : 4'd0;
        o_result.channel_on   = n_enabled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_period_load <= '0;
            r_sweep_subtract    <= 1'b0;
            r_sweep_shift       <= '0;
            r_duty_select       <= '0;
            r_length_count      <= '0;
            r_volume_load       <= '0;
            r_env_increase      <= 1'b0;
            r_env_period_load   <= '0;
            r_freq_value        <= '0;
            r_length_on         <= 1'b0;
            r_enabled           <= 1'b0;
            r_sweep_active      <= 1'b0;
            r_shadow_freq       <= '0;
            r_sweep_timer       <= '0;
            r_env_timer         <= '0;
            r_env_running       <= 1'b0;
            r_cur_volume        <= '0;
            r_period_timer      <= '0;
            r_duty_step         <= '0;
            r_trigger_seen      <= 1'b0;
        end else if (i_fire) begin
            r_sweep_period_load <= n_sweep_period_load;
            r_sweep_subtract    <= n_sweep_subtract;
            r_sweep_shift       <= n_sweep_shift;
            r_duty_select       <= n_duty_select;
            r_length_count      <= n_length_count;
            r_volume_load       <= n_volume_load;
            r_env_increase      <= n_env_increase;
            r_env_period_load   <= n_env_period_load;
            r_freq_value        <= n_freq_value;
            r_length_on         <= n_length_on;
            r_enabled           <= n_enabled;
            r_sweep_active      <= n_sweep_active;
            r_shadow_freq       <= n_shadow_freq;
            r_sweep_timer       <= n_sweep_timer;
            r_env_timer         <= n_env_timer;
            r_env_running       <= n_env_running;
            r_cur_volume        <= n_cur_volume;
            r_period_timer      <= n_period_timer;
            r_duty_step         <= n_duty_step;
            r_trigger_seen      <= n_trigger_seen;
        end
    end

    a_length_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == sqc_pkg::ACT_LENGTH && r_length_on &&
        r_length_count == LEN_W'(1) |=> !r_enabled)
        else $error("length expiry did not stop the channel");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_freq_value) && $stable(r_enabled) && $stable(r_cur_volume))
        else $error("channel state moved without a transfer");

    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == sqc_pkg::ACT_TICK && r_period_timer > PT_W'(1)
        |=> r_period_timer == $past(r_period_timer) - PT_W'(1))
        else $error("period timer did not count down");

    a_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == sqc_pkg::ACT_WRITE &&
        i_item.reg_index == sqc_pkg::REG_FREQ_HI && i_item.write_data[7] &&
        r_sweep_shift == 3'd0 |=> r_enabled && r_length_count != '0)
        else $error("trigger did not start the channel");

endmodule

// ===== sv/sqc_out_stage.sv =====
module sqc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sqc_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output sqc_pkg::t_result o_result
);

    logic             r_valid;
    sqc_pkg::t_result r_result;

    assign o_can_load = ~r_valid | i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== sv/square_wave_sound_channel.sv =====
// An accepted item waits in the input register; its result is registered in the output stage.
// Throughput: one item per cycle unless i_out_ready stalls; a single state pass per item.
// The input register is freed in the same cycle the result register takes its result.
// Reset (i_rst_n low, synchronous) clears all channel state and empties both stages.
module square_wave_sound_channel (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_action,
    input  logic [2:0] i_reg_index,
    input  logic [7:0] i_write_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic [3:0] o_output_level,
    output logic       o_channel_on
);

    sqc_pkg::t_item   in_item;
    sqc_pkg::t_item   stage_item;
    sqc_pkg::t_result core_result;
    sqc_pkg::t_result out_result;
    logic             stage_valid;
    logic             can_load;
    logic             fire;

    assign in_item.action     = i_action;
    assign in_item.reg_index  = i_reg_index;
    assign in_item.write_data = i_write_data;

    assign fire = stage_valid & can_load;

    sqc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_pop   (fire),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    sqc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    sqc_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (core_result),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_read_data    = out_result.read_data;
    assign o_output_level = out_result.output_level;
    assign o_channel_on   = out_result.channel_on;

endmodule

// ===== bench/tb_square_wave_sound_channel.sv =====
module tb_square_wave_sound_channel;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    // Duty waveforms, played from the top bit down.
    localparam logic [7:0] WAVE_SHAPES [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

    typedef struct {
        sqc_pkg::t_item item;
        logic           wait_idle;
    } t_pending;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] action = sqc_pkg::ACT_READ;
    logic [2:0] reg_index = sqc_pkg::REG_SWEEP;
    logic [7:0] write_data = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic [3:0] output_level;
    logic       channel_on;

    t_pending         pending_items[$];
    sqc_pkg::t_result expected_outputs[$];
    sqc_pkg::t_result next_expect;
    sqc_pkg::t_result want;
    logic     take;
    logic     ready_nxt;
    int       useful_items = 0;
    int       errors = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       stall_cnt = 0;
    int       stall_mode = 0;
    int       cycles = 0;

    // Channel model state.
    logic [2:0]  sw_period, sw_shift;
    logic        sw_sub, sw_en;
    logic [1:0]  duty_sel;
    logic [6:0]  len_cnt;
    logic [3:0]  vol_init, volume;
    logic        env_up, env_run;
    logic [2:0]  env_period;
    logic [10:0] freq, sw_freq;
    logic        len_en, chan_en, trig_bit;
    logic [3:0]  sw_timer, env_timer;
    logic [13:0] tick_timer;
    logic [2:0]  duty_pos;

    square_wave_sound_channel i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_action       (action),
        .i_reg_index    (reg_index),
        .i_write_data   (write_data),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_read_data    (read_data),
        .o_output_level (output_level),
        .o_channel_on   (channel_on)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Next sweep frequency; an overflow past 11 bits silences the channel.
    function automatic logic [11:0] sweep_target();
        logic [11:0] nxt;
        if (sw_sub) begin
            nxt = {1'b0, sw_freq} - (sw_freq >> sw_shift);
        end else begin
            nxt = {1'b0, sw_freq} + (sw_freq >> sw_shift);
        end
        if (nxt > 12'd2047) begin
            chan_en = 1'b0;
        end
        return nxt;
    endfunction

    function automatic logic [13:0] tick_reload();
        return {12'd2048 - {1'b0, freq}, 2'b00};
    endfunction

    task automatic channel_step(input sqc_pkg::t_item it, output sqc_pkg::t_result res);
        logic [7:0]  d;
        logic [7:0]  rd;
        logic [11:0] nxt;
        d  = it.write_data;
        rd = 8'h00;
        case (it.action)
            sqc_pkg::ACT_WRITE: begin
                case (it.reg_index)
                    sqc_pkg::REG_SWEEP: begin
                        sw_period = d[6:4];
                        sw_sub    = d[3];
                        sw_shift  = d[2:0];
                    end
                    sqc_pkg::REG_DUTY: begin
                        duty_sel = d[7:6];
                        len_cnt  = 7'(sqc_pkg::LENGTH_MAX - int'(d[5:0]));
                    end
                    sqc_pkg::REG_ENV: begin
                        vol_init   = d[7:4];
                        env_up     = d[3];
                        env_period = d[2:0];
                    end
                    sqc_pkg::REG_FREQ_LO: freq[7:0] = d;
                    sqc_pkg::REG_FREQ_HI: begin
                        len_en     = d[6];
                        freq[10:8] = d[2:0];
                        trig_bit   = d[7];
                        if (d[7]) begin
                            chan_en = 1'b1;
                            if (len_cnt == 0) begin
                                len_cnt = 7'(sqc_pkg::LENGTH_MAX);
                            end
                            tick_timer = tick_reload();
                            env_timer  = {1'b0, env_period};
                            volume     = vol_init;
                            env_run    = 1'b1;
                            sw_freq    = freq;
                            sw_timer   = (sw_period != 0) ? {1'b0, sw_period} : 4'd8;
                            sw_en      = (sw_period != 0 || sw_shift != 0);
                            if (sw_shift != 0) begin
                                void'(sweep_target());
                            end
                        end
                    end
                    default: ;
                endcase
            end
            sqc_pkg::ACT_READ: begin
                case (it.reg_index)
                    sqc_pkg::REG_SWEEP:   rd = {1'b0, sw_period, sw_sub, sw_shift};
                    sqc_pkg::REG_DUTY:
                        rd = {duty_sel, 6'(sqc_pkg::LENGTH_MAX - int'(len_cnt))};
                    sqc_pkg::REG_ENV:     rd = {vol_init, env_up, env_period};
                    sqc_pkg::REG_FREQ_LO: rd = freq[7:0];
                    sqc_pkg::REG_FREQ_HI: rd = {trig_bit, len_en, 3'b000, freq[10:8]};
                    default:              rd = 8'h00;
                endcase
            end
            sqc_pkg::ACT_TICK: begin
                if (tick_timer <= 1) begin
                    tick_timer = tick_reload();
                    duty_pos   = duty_pos + 3'd1;
                end else begin
                    tick_timer = tick_timer - 14'd1;
                end
            end
            sqc_pkg::ACT_LENGTH: begin
                if (len_en && len_cnt != 0) begin
                    len_cnt = len_cnt - 7'd1;
                    if (len_cnt == 0) begin
                        chan_en = 1'b0;
                    end
                end
            end
            sqc_pkg::ACT_SWEEP: begin
                if (sw_timer != 0) begin
                    sw_timer = sw_timer - 4'd1;
                end
                if (sw_timer == 0) begin
                    sw_timer = (sw_period != 0) ? {1'b0, sw_period} : 4'd8;
                    if (sw_en && sw_period != 0) begin
                        nxt = sweep_target();
                        if (nxt <= 12'd2047 && sw_shift != 0) begin
                            sw_freq = nxt[10:0];
                            freq    = nxt[10:0];
                            void'(sweep_target());
                        end
                    end
                end
            end
            sqc_pkg::ACT_ENV: begin
                if (env_period != 0) begin
                    if (env_timer != 0) begin
                        env_timer = env_timer - 4'd1;
                    end
                    if (env_timer == 0) begin
                        env_timer = {1'b0, env_period};
                        if (env_run) begin
                            if (env_up && volume < 4'd15) begin
                                volume = volume + 4'd1;
                            end else if (!env_up && volume > 4'd0) begin
                                volume = volume - 4'd1;
                            end
                            if (volume == 4'd0 || volume == 4'd15) begin
                                env_run = 1'b0;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        res.read_data    = rd;
        res.output_level = (chan_en && WAVE_SHAPES[duty_sel][3'd7 - duty_pos]) ? volume : 4'd0;
        res.channel_on   = chan_en;
    endtask

    function automatic void add_item(input logic [2:0] act, input logic [2:0] idx,
                                     input logic [7:0] d, input logic wait_idle);
        t_pending p;
        p.item.action     = act;
        p.item.reg_index  = idx;
        p.item.write_data = d;
        p.wait_idle       = wait_idle;
        pending_items.push_back(p);
        if (act <= sqc_pkg::ACT_ENV &&
            !((act == sqc_pkg::ACT_WRITE || act == sqc_pkg::ACT_READ) &&
              idx > sqc_pkg::REG_FREQ_HI)) begin
            useful_items++;
        end
    endfunction

    // Sender: one transfer per accepted item, in bursts separated by gaps.
    always @(posedge clk) begin
        take = in_valid && in_ready;
        if (!rst_n) begin
            {sw_period, sw_shift, sw_sub, sw_en, duty_sel, len_cnt} = '0;
            {vol_init, volume, env_up, env_run, env_period} = '0;
            {freq, sw_freq, len_en, chan_en, trig_bit} = '0;
            {sw_timer, env_timer, tick_timer, duty_pos} = '0;
            in_valid <= 1'b0;
        end else begin
            if (take) begin
                channel_step(pending_items[0].item, next_expect);
                expected_outputs.push_back(next_expect);
                void'(pending_items.pop_front());
            end
            if (in_valid && !take) begin
                // Hold the current transfer until it is taken.
            end else if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_items.size() == 0 ||
                         (pending_items[0].wait_idle && expected_outputs.size() != 0)) begin
                in_valid <= 1'b0;
            end else begin
                in_valid   <= 1'b1;
                action     <= pending_items[0].item.action;
                reg_index  <= pending_items[0].item.reg_index;
                write_data <= pending_items[0].item.write_data;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Receiver: checks each result transfer and stalls on a changing pattern.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_outputs.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (read_data !== want.read_data) begin
                        $error("read_data: expected %0d, got %0d", want.read_data, read_data);
                        errors++;
                    end
                    if (output_level !== want.output_level) begin
                        $error("output_level: expected %0d, got %0d",
                               want.output_level, output_level);
                        errors++;
                    end
                    if (channel_on !== want.channel_on) begin
                        $error("channel_on: expected %0d, got %0d", want.channel_on, channel_on);
                        errors++;
                    end
                end
            end
            stall_cnt++;
            if (stall_cnt % 48 == 0) begin
                stall_mode = $urandom_range(0, 4);
            end
            case (stall_mode)
                0:       ready_nxt = 1'b1;
                1:       ready_nxt = (stall_cnt % 2 == 0);
                2:       ready_nxt = ($urandom_range(0, 3) != 0);
                3:       ready_nxt = ($urandom_range(0, 3) == 0);
                default: ready_nxt = (stall_cnt % 8 < 5);
            endcase
            out_ready <= ready_nxt;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int scene;
        int body;
        int pick;
        logic [2:0] idx;
        scene = 0;

        // Directed part: a tick and a sweep clock straight after reset find both timers at
        // zero, then all-ones and all-zeros writes, odd indexes and unknown actions.
        add_item(sqc_pkg::ACT_TICK, sqc_pkg::REG_SWEEP, 8'h00, 1'b0);
        add_item(sqc_pkg::ACT_SWEEP, sqc_pkg::REG_SWEEP, 8'h00, 1'b0);
        add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_SWEEP, 8'hFF, 1'b0);
        add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_DUTY, 8'hFF, 1'b0);
        add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_ENV, 8'hFF, 1'b0);
        add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_FREQ_LO, 8'hFF, 1'b0);
        // Trigger at the top frequency with the sweep counting down.
        add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_FREQ_HI, 8'hC7, 1'b0);
        for (int r = 0; r <= 4; r++) begin
            add_item(sqc_pkg::ACT_READ, 3'(r), 8'h00, 1'b0);
        end
        add_item(sqc_pkg::ACT_WRITE, 3'd5, 8'hFF, 1'b0);
        add_item(sqc_pkg::ACT_READ, 3'd7, 8'h00, 1'b0);
        add_item(3'd6, 3'd2, 8'hAA, 1'b0);
        add_item(3'd7, 3'd6, 8'h55, 1'b0);
        add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_ENV, 8'h00, 1'b0);
        add_item(sqc_pkg::ACT_ENV, sqc_pkg::REG_SWEEP, 8'h00, 1'b0);
        // Length runs out on the first length clock, then a trigger must reload it to full scale.
        add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_DUTY, 8'h3F, 1'b0);
        add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_FREQ_HI, 8'hC0, 1'b0);
        add_item(sqc_pkg::ACT_LENGTH, sqc_pkg::REG_SWEEP, 8'h00, 1'b0);
        add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_FREQ_HI, 8'h80, 1'b0);
        // The sender drains the block completely before this read.
        add_item(sqc_pkg::ACT_READ, sqc_pkg::REG_DUTY, 8'h00, 1'b1);

        // Random scenes: set the channel up, write FREQ_HI (mostly with the trigger bit), then exercise it.
        while (useful_items < 400) begin
            scene++;
            if ($urandom_range(0, 4) != 0) begin
                add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_SWEEP, $urandom_range(0, 1) ?
                         {1'($urandom), 3'($urandom_range(1, 2)), 1'($urandom),
                          3'($urandom_range(1, 7))} : 8'($urandom), scene % 6 == 1);
            end
            if ($urandom_range(0, 4) != 0) begin
                add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_DUTY,
                         {2'($urandom), $urandom_range(0, 1) ?
                          6'($urandom_range(56, 63)) : 6'($urandom)}, 1'b0);
            end
            if ($urandom_range(0, 4) != 0) begin
                add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_ENV, $urandom_range(0, 1) ?
                         {4'($urandom), 1'($urandom), 3'($urandom_range(0, 3))} :
                         8'($urandom), 1'b0);
            end
            if ($urandom_range(0, 4) != 0) begin
                add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_FREQ_LO, $urandom_range(0, 2) != 0 ?
                         8'($urandom_range(200, 255)) : 8'($urandom), 1'b0);
            end
            add_item(sqc_pkg::ACT_WRITE, sqc_pkg::REG_FREQ_HI,
                     {1'($urandom_range(0, 9) != 0), 1'($urandom), 3'($urandom),
                      $urandom_range(0, 2) != 0 ? 3'd7 : 3'($urandom)}, 1'b0);
            body = $urandom_range(15, 45);
            for (int k = 0; k < body; k++) begin
                pick = $urandom_range(0, 99);
                idx  = 3'($urandom_range(0, 4));
                if (pick < 45) begin
                    add_item(sqc_pkg::ACT_TICK, 3'($urandom), 8'($urandom), 1'b0);
                end else if (pick < 55) begin
                    add_item(sqc_pkg::ACT_LENGTH, 3'($urandom), 8'($urandom), 1'b0);
                end else if (pick < 63) begin
                    add_item(sqc_pkg::ACT_SWEEP, 3'($urandom), 8'($urandom), 1'b0);
                end else if (pick < 73) begin
                    add_item(sqc_pkg::ACT_ENV, 3'($urandom), 8'($urandom), 1'b0);
                end else if (pick < 84) begin
                    add_item(sqc_pkg::ACT_READ, idx, 8'($urandom), 1'b0);
                end else if (pick < 93) begin
                    add_item(sqc_pkg::ACT_WRITE, idx, 8'($urandom), 1'b0);
                end else if (pick < 97) begin
                    add_item(3'($urandom_range(6, 7)), 3'($urandom), 8'($urandom), 1'b0);
                end else begin
                    add_item(3'($urandom_range(0, 1)), 3'($urandom_range(5, 7)),
                             8'($urandom), 1'b0);
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_outputs.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
